// ----- rtl/fpgc_pkg.sv -----
// ----------------------------------------------------------------------------
// fpgc_pkg: shared types and constants for the page validity tracker
// Field widths, operation codes, register indexes, controller states and
// the result record that the top level and its submodules share.
// ----------------------------------------------------------------------------
`default_nettype none

package fpgc_pkg;

	// Default geometry
	localparam int NUM_BLOCKS_DEF      = 256;
	localparam int PAGES_PER_BLOCK_DEF = 64;

	// Fixed field widths
	localparam int OP_W       = 2;
	localparam int ADDR_W     = 14;
	localparam int BIDX_W     = 8;
	localparam int BASE_W     = 8;
	localparam int SCNT_W     = 9;
	localparam int CFG_DATA_W = 9;
	localparam int CFG_IDX_W  = 1;
	localparam int OUT_BLK_W  = 8;
	localparam int OUT_CNT_W  = 7;

	// Internal block index width, wide enough for any block count in range
	localparam int XW = 13;

	// Reset value of the scan length register
	localparam logic [SCNT_W-1:0] SCAN_COUNT_RST = 9'd256;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SCAN_BASE  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SCAN_COUNT = 1'b1;

	// Operation codes
	typedef enum logic [OP_W-1:0] {
		OP_INVALIDATE = 2'd0,
		OP_SELECT     = 2'd1,
		OP_FREE       = 2'd2
	} op_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_INV_RD,
		ST_INV_WR,
		ST_SCAN,
		ST_SCAN_END,
		ST_FREE,
		ST_RESP
	} state_t;

	// One result item
	typedef struct packed {
		logic                 victim_found;
		logic [OUT_BLK_W-1:0] victim_block;
		logic [OUT_CNT_W-1:0] victim_invalid_count;
		logic                 repeat_invalidate;
		logic                 block_all_invalid;
	} res_t;

	// Width of the block number taken from a page address
	function automatic int blk_w(input int ppb);
		return ADDR_W - $clog2(ppb) + 1;
	endfunction

	// Width of the page number within a block
	function automatic int page_w(input int ppb);
		return $clog2(ppb);
	endfunction

endpackage

`default_nettype wire

// ----- rtl/fpgc_mem.sv -----
// ----------------------------------------------------------------------------
// fpgc_mem: per-block validity store
// Simple dual-port synchronous RAM, one write and one read port, with the
// read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module fpgc_mem #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 71
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/fpgc_split.sv -----
// ----------------------------------------------------------------------------
// fpgc_split: page address to block and page number
// Divides the page address by the pages per block with a reciprocal
// multiply (exact over the whole address range), registers the quotient,
// and forms the remainder from the registered values.
// ----------------------------------------------------------------------------
`default_nettype none

module fpgc_split #(
	parameter int PAGES_PER_BLOCK = fpgc_pkg::PAGES_PER_BLOCK_DEF
) (
	input  wire logic                                            clk,
	input  wire logic                                            load,
	input  wire logic [fpgc_pkg::ADDR_W-1:0]                     addr,
	output      logic [fpgc_pkg::blk_w(PAGES_PER_BLOCK)-1:0]     blk,
	output      logic [fpgc_pkg::page_w(PAGES_PER_BLOCK)-1:0]    page
);

	import fpgc_pkg::*;

	localparam int QW    = blk_w(PAGES_PER_BLOCK);
	localparam int PW    = page_w(PAGES_PER_BLOCK);
	localparam int SHIFT = 24;
	localparam int RCW   = 25;
	localparam int PRW   = ADDR_W + RCW;
	localparam int unsigned RECIP = (1 << SHIFT) / PAGES_PER_BLOCK + 1;

	logic [PRW-1:0]    prod;
	logic [ADDR_W-1:0] addr_s1;
	logic [ADDR_W-1:0] base;
	logic [ADDR_W-1:0] diff;

	// Quotient by reciprocal multiply
	assign prod = PRW'(addr) * PRW'(RECIP);

	// Hold address and quotient for the item under way
	always_ff @(posedge clk) begin
		if (load) begin
			addr_s1 <= addr;
			blk     <= prod[SHIFT +: QW];
		end
	end

	// Remainder from the registered quotient
	assign base = ADDR_W'(blk) * ADDR_W'(PAGES_PER_BLOCK);
	assign diff = addr_s1 - base;
	assign page = diff[PW-1:0];

endmodule

`default_nettype wire

// ----- rtl/flash_page_invalidation_gc_victim.sv -----
// ----------------------------------------------------------------------------
// flash_page_invalidation_gc_victim: flash validity tracker with greedy
// garbage-collection victim selection
// Keeps an invalid-page bitmap and an invalid count per block in one RAM,
// marks pages invalid, frees blocks and picks the block with the most
// invalid pages over a configured range (lowest index on ties).
//
//   Channel  Signals                                   Direction
//   -------  ----------------------------------------  ---------
//   config   cfg_write, cfg_index, cfg_data            in
//   request  in_valid, in_stall, operation, page_address, block_index
//   result   out_valid, out_stall, victim_found, victim_block,
//            victim_invalid_count, repeat_invalidate, block_all_invalid
//
// An invalidate does a RAM read-modify-write, a free one RAM write and an
// unknown code goes straight to the result; a select reads the RAM once per
// block in range and then waits for the last scan read to drain.
// One item is in work at a time; the next is taken once the previous result
// sits in the output register.
// After reset the RAM is cleared one block a cycle, every block in turn, with
// in_stall high; configuration writes are taken throughout.
// A stalled result holds in the output register while a new item proceeds.
// ----------------------------------------------------------------------------
`default_nettype none

module flash_page_invalidation_gc_victim #(
	parameter int NUM_BLOCKS      = fpgc_pkg::NUM_BLOCKS_DEF,
	parameter int PAGES_PER_BLOCK = fpgc_pkg::PAGES_PER_BLOCK_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,

	input  wire logic                               cfg_write,
	input  wire logic [fpgc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [fpgc_pkg::CFG_DATA_W-1:0]    cfg_data,

	input  wire logic                               in_valid,
	output      logic                               in_stall,
	input  wire logic [fpgc_pkg::OP_W-1:0]          operation,
	input  wire logic [fpgc_pkg::ADDR_W-1:0]        page_address,
	input  wire logic [fpgc_pkg::BIDX_W-1:0]        block_index,

	output      logic                               out_valid,
	input  wire logic                               out_stall,
	output      logic                               victim_found,
	output      logic [fpgc_pkg::OUT_BLK_W-1:0]     victim_block,
	output      logic [fpgc_pkg::OUT_CNT_W-1:0]     victim_invalid_count,
	output      logic                               repeat_invalidate,
	output      logic                               block_all_invalid
);

	import fpgc_pkg::*;

	localparam int BW = $clog2(NUM_BLOCKS);
	localparam int QW = blk_w(PAGES_PER_BLOCK);
	localparam int PW = page_w(PAGES_PER_BLOCK);
	localparam int CW = $clog2(PAGES_PER_BLOCK + 1);
	localparam int MW = PAGES_PER_BLOCK + CW;
	localparam logic [XW-1:0] NUM_X    = XW'(NUM_BLOCKS);
	localparam logic [CW-1:0] FULL_CNT = CW'(PAGES_PER_BLOCK);

	state_t state_q, state_d;

	logic                       accept;
	logic [BASE_W-1:0]          scan_base_q;
	logic [SCNT_W-1:0]          scan_count_q;
	logic [BIDX_W-1:0]          bidx_q;
	logic [XW-1:0]              clr_q;
	logic [XW-1:0]              scan_q;
	logic [XW-1:0]              end_q;
	logic [XW-1:0]              scan_sum;
	logic [XW-1:0]              scan_end;
	logic [XW-1:0]              blk_x;
	logic [XW-1:0]              bidx_x;
	logic [XW-1:0]              rd_blk_s1;
	logic                       rd_valid_s1;
	logic [XW-1:0]              best_blk_q;
	logic [CW-1:0]              best_cnt_q;
	logic                       issue;

	logic [QW-1:0]              blk_s1;
	logic [PW-1:0]              page_s1;

	logic                       mem_we;
	logic [BW-1:0]              mem_waddr;
	logic [MW-1:0]              mem_wdata;
	logic                       mem_re;
	logic [BW-1:0]              mem_raddr;
	logic [MW-1:0]              mem_rdata;

	logic [PAGES_PER_BLOCK-1:0] rd_bits;
	logic [CW-1:0]              rd_cnt;
	logic                       rep;
	logic [PAGES_PER_BLOCK-1:0] bits_new;
	logic [CW-1:0]              cnt_new;

	res_t                       res_q;
	res_t                       out_q;
	logic                       out_valid_q;
	logic                       out_load;

	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);

	// Address split
	fpgc_split #(
		.PAGES_PER_BLOCK(PAGES_PER_BLOCK)
	) u_split (
		.clk  (clk),
		.load (accept),
		.addr (page_address),
		.blk  (blk_s1),
		.page (page_s1)
	);

	// Validity store: {count, bitmap} per block
	fpgc_mem #(
		.DEPTH(NUM_BLOCKS),
		.WIDTH(MW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_base_q  <= '0;
			scan_count_q <= SCAN_COUNT_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_SCAN_BASE:  scan_base_q  <= cfg_data[BASE_W-1:0];
				REG_SCAN_COUNT: scan_count_q <= cfg_data[SCNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Scan bound: end of range clipped to the last block
	assign scan_sum = XW'(scan_base_q) + XW'(scan_count_q);
	assign scan_end = (scan_sum < NUM_X) ? scan_sum : NUM_X;
	assign blk_x    = XW'(blk_s1);
	assign bidx_x   = XW'(bidx_q);

	// Read-modify-write of one block entry
	assign rd_bits  = mem_rdata[PAGES_PER_BLOCK-1:0];
	assign rd_cnt   = mem_rdata[MW-1 -: CW];
	assign rep      = rd_bits[page_s1];
	assign bits_new = rd_bits | (PAGES_PER_BLOCK'(1) << page_s1);
	assign cnt_new  = (!rep && (rd_cnt < FULL_CNT)) ? rd_cnt + CW'(1) : rd_cnt;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and RAM control
	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = '0;
		issue     = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q[BW-1:0];
				if (clr_q == NUM_X - XW'(1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					case (operation)
						OP_INVALIDATE: state_d = ST_INV_RD;
						OP_SELECT:     state_d = ST_SCAN;
						OP_FREE:       state_d = ST_FREE;
						default:       state_d = ST_RESP;
					endcase
				end
			end
			ST_INV_RD: begin
				if (blk_x < NUM_X) begin
					mem_re    = 1'b1;
					mem_raddr = blk_x[BW-1:0];
					state_d   = ST_INV_WR;
				end else begin
					state_d = ST_RESP;
				end
			end
			ST_INV_WR: begin
				mem_we    = 1'b1;
				mem_waddr = blk_x[BW-1:0];
				mem_wdata = {cnt_new, bits_new};
				state_d   = ST_RESP;
			end
			ST_SCAN: begin
				if (scan_q < end_q) begin
					issue     = 1'b1;
					mem_re    = 1'b1;
					mem_raddr = scan_q[BW-1:0];
				end else if (!rd_valid_s1) begin
					state_d = ST_SCAN_END;
				end
			end
			ST_SCAN_END: begin
				state_d = ST_RESP;
			end
			ST_FREE: begin
				if (bidx_x < NUM_X) begin
					mem_we    = 1'b1;
					mem_waddr = bidx_x[BW-1:0];
				end
				state_d = ST_RESP;
			end
			ST_RESP: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Clear sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (state_q == ST_CLEAR) begin
			clr_q <= clr_q + XW'(1);
		end
	end

	// Hold the block index of a free
	always_ff @(posedge clk) begin
		if (accept) begin
			bidx_q <= block_index;
		end
	end

	// Scan address and read tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			scan_q <= XW'(scan_base_q);
			end_q  <= scan_end;
		end else if (issue) begin
			scan_q <= scan_q + XW'(1);
		end
		rd_blk_s1 <= scan_q;
	end

	// Track the first block with the largest count
	always_ff @(posedge clk) begin
		if (accept) begin
			best_cnt_q <= '0;
			best_blk_q <= '0;
		end else if (rd_valid_s1 && (rd_cnt > best_cnt_q)) begin
			best_cnt_q <= rd_cnt;
			best_blk_q <= rd_blk_s1;
		end
	end

	// Build the result of the item in work
	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= '0;
		end else if (state_q == ST_INV_WR) begin
			res_q.repeat_invalidate <= rep;
			res_q.block_all_invalid <= (cnt_new == FULL_CNT);
		end else if ((state_q == ST_SCAN_END) && (best_cnt_q != '0)) begin
			res_q.victim_found         <= 1'b1;
			res_q.victim_block         <= best_blk_q[OUT_BLK_W-1:0];
			res_q.victim_invalid_count <= OUT_CNT_W'(best_cnt_q);
			res_q.block_all_invalid    <= (best_cnt_q == FULL_CNT);
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= res_q;
		end
	end

	assign out_valid            = out_valid_q;
	assign victim_found         = out_q.victim_found;
	assign victim_block         = out_q.victim_block;
	assign victim_invalid_count = out_q.victim_invalid_count;
	assign repeat_invalidate    = out_q.repeat_invalidate;
	assign block_all_invalid    = out_q.block_all_invalid;

	// Scan reads stay inside the store
	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> (scan_q < NUM_X))
		else $error("scan read beyond last block");

	// Invalid count never passes the pages per block
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INV_WR) |-> (cnt_new <= FULL_CNT))
		else $error("invalid count overflow");

	// Read and write of the store never overlap
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("read and write of the store in one cycle");

	// A found victim carries a nonzero count
	a_found_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_RESP) && res_q.victim_found) |-> (res_q.victim_invalid_count != '0))
		else $error("victim found with zero count");

	// Result register is loaded only after the item finished its work
	a_load_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_valid_q && (state_q == ST_IDLE))
		else $error("result transfer out of sequence");

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: page validity tracker and greedy victim selection
// Drives invalidate, select, free and reserved requests with random gaps and
// output stalls. A scoreboard keeps its own page bitmaps, invalid counts and
// scan range, predicts one result per accepted request and checks each result
// transfer in order. Scan settings change between phases while the block idles.
// ----------------------------------------------------------------------------

module testbench;

	import fpgc_pkg::*;

	localparam int NB              = NUM_BLOCKS_DEF;
	localparam int PPB             = PAGES_PER_BLOCK_DEF;
	localparam int ITEMS_TOTAL     = 1120;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int TAIL_CYCLES     = 300;
	localparam int LIMIT_CYCLES    = 2000000;

	// Code with no operation behind it
	localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

	// Expected-result store and bitmap/count mirror of the block
	class invalid_map_board;
		logic [PPB-1:0]       page_bits [NB];
		logic [OUT_CNT_W-1:0] page_cnt [NB];
		logic [BASE_W-1:0]    scan_start;
		logic [SCNT_W-1:0]    scan_len;
		res_t                 pending_results [$];
		int errors, checked, requests;
		int n_inv, n_sel, n_free, n_other, n_found, n_full, n_repeat;

		function new();
			foreach (page_bits[i]) begin
				page_bits[i] = '0;
				page_cnt[i] = '0;
			end
			scan_start = '0;
			scan_len = SCAN_COUNT_RST;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == REG_SCAN_BASE)
				scan_start = data[BASE_W-1:0];
			else if (idx == REG_SCAN_COUNT)
				scan_len = data[SCNT_W-1:0];
		endfunction

		// Update the mirror for one accepted request and queue its result
		function void apply_request(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr,
				logic [BIDX_W-1:0] bidx);
			res_t want;
			int blk, pg, b, best, bestcnt;
			bit any;
			want = '0;
			requests++;
			case (op)
				OP_INVALIDATE: begin
					n_inv++;
					blk = int'(addr) / PPB;
					pg = int'(addr) % PPB;
					if (blk < NB) begin
						if (page_bits[blk][pg]) begin
							want.repeat_invalidate = 1'b1;
							n_repeat++;
						end else begin
							page_bits[blk][pg] = 1'b1;
							if (page_cnt[blk] < PPB)
								page_cnt[blk]++;
						end
						want.block_all_invalid = (page_cnt[blk] == PPB);
					end
				end
				OP_SELECT: begin
					n_sel++;
					any = 1'b0;
					best = 0;
					bestcnt = 0;
					for (int i = 0; i < int'(scan_len); i++) begin
						b = int'(scan_start) + i;
						if (b >= NB)
							break;
						if (!any || int'(page_cnt[b]) > bestcnt) begin
							best = b;
							bestcnt = int'(page_cnt[b]);
							any = 1'b1;
						end
					end
					if (any && bestcnt != 0) begin
						want.victim_found = 1'b1;
						want.victim_block = best[OUT_BLK_W-1:0];
						want.victim_invalid_count = bestcnt[OUT_CNT_W-1:0];
						want.block_all_invalid = (bestcnt == PPB);
						n_found++;
					end
				end
				OP_FREE: begin
					n_free++;
					if (bidx < NB) begin
						page_bits[bidx] = '0;
						page_cnt[bidx] = '0;
					end
				end
				default: n_other++;
			endcase
			if (want.block_all_invalid)
				n_full++;
			pending_results.push_back(want);
		endfunction

		// Check one result transfer against the oldest expectation
		function void compare_result(res_t got);
			res_t want;
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("[%0t] result with nothing expected: ", $realtime,
						"found %b blk %0d cnt %0d ", got.victim_found,
						got.victim_block, got.victim_invalid_count,
						"rep %b full %b", got.repeat_invalidate,
						got.block_all_invalid);
				return;
			end
			want = pending_results.pop_front();
			checked++;
			if (got.victim_found !== want.victim_found ||
					got.victim_block !== want.victim_block ||
					got.victim_invalid_count !== want.victim_invalid_count ||
					got.repeat_invalidate !== want.repeat_invalidate ||
					got.block_all_invalid !== want.block_all_invalid) begin
				errors++;
				if (errors <= 10)
					$display("[%0t] result %0d: ", $realtime, checked,
						"expected found %b blk %0d cnt %0d rep %b full %b, ",
						want.victim_found, want.victim_block,
						want.victim_invalid_count, want.repeat_invalidate,
						want.block_all_invalid,
						"got found %b blk %0d cnt %0d rep %b full %b",
						got.victim_found, got.victim_block,
						got.victim_invalid_count, got.repeat_invalidate,
						got.block_all_invalid);
			end
		endfunction

		function int pending();
			return pending_results.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [OP_W-1:0] operation = '0;
	logic [ADDR_W-1:0] page_address = '0;
	logic [BIDX_W-1:0] block_index = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic victim_found;
	logic [OUT_BLK_W-1:0] victim_block;
	logic [OUT_CNT_W-1:0] victim_invalid_count;
	logic repeat_invalidate;
	logic block_all_invalid;

	// Shared between the request and result sides
	bit calm = 1'b0;
	bit hold_off_req = 1'b0;
	logic [BIDX_W-1:0] hot [3];
	int settings_used = 0;
	res_t seen_result;

	invalid_map_board board = new();

	flash_page_invalidation_gc_victim #(
		.NUM_BLOCKS(NB),
		.PAGES_PER_BLOCK(PPB)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.page_address(page_address),
		.block_index(block_index),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.victim_found(victim_found),
		.victim_block(victim_block),
		.victim_invalid_count(victim_invalid_count),
		.repeat_invalidate(repeat_invalidate),
		.block_all_invalid(block_all_invalid)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Gap length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Offer one request and hold it until its transfer
	task automatic send_item(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
			input logic [BIDX_W-1:0] bidx);
		int gap;
		gap = calm ? 0 : pick_gap();
		if (gap != 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		operation = op;
		page_address = addr;
		block_index = bidx;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		board.apply_request(op, addr, bidx);
		@(negedge clk);
	endtask

	task automatic invalidate(input int blk, input int pg);
		send_item(OP_INVALIDATE, ADDR_W'(blk * PPB + pg), BIDX_W'($urandom));
	endtask

	task automatic select_victim();
		send_item(OP_SELECT, ADDR_W'($urandom), BIDX_W'($urandom));
	endtask

	task automatic free_block(input int blk);
		send_item(OP_FREE, ADDR_W'($urandom), BIDX_W'(blk));
	endtask

	// Stop offering and wait for every outstanding result
	task automatic drain();
		in_valid = 1'b0;
		while (board.pending() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_write = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		board.write_reg(idx, data);
		@(negedge clk);
		cfg_write = 1'b0;
	endtask

	task automatic set_scan(input logic [CFG_DATA_W-1:0] base, input logic [CFG_DATA_W-1:0] len);
		write_reg(REG_SCAN_BASE, base);
		write_reg(REG_SCAN_COUNT, len);
		settings_used++;
	endtask

	// Cycle through extreme and random scan ranges
	task automatic pick_setting(input int idx);
		case (idx % 8)
			0: set_scan(9'd0, 9'd256);
			1: set_scan(9'h1FF, 9'd1);
			2: set_scan(9'd0, 9'd0);
			3: set_scan(9'd200, 9'd256);
			4: set_scan(9'd0, 9'h1FF);
			5: set_scan(9'd128, 9'd128);
			default: set_scan(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom_range(1, 256)));
		endcase
	endtask

	// Pick busy blocks, mostly inside the current scan range
	task automatic choose_hot();
		int span;
		span = int'(board.scan_len);
		if (span > NB - int'(board.scan_start))
			span = NB - int'(board.scan_start);
		foreach (hot[i]) begin
			if (span > 0 && $urandom_range(0, 9) < 7)
				hot[i] = BIDX_W'(int'(board.scan_start) + $urandom_range(0, span - 1));
			else
				hot[i] = BIDX_W'($urandom_range(0, NB - 1));
		end
	endtask

	// Random mix of all operations around the busy blocks
	task automatic mixed_burst(input int n);
		int r;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			if (r < 68)
				invalidate(($urandom_range(0, 99) < 85) ? hot[$urandom_range(0, 2)]
					: $urandom_range(0, NB - 1), $urandom_range(0, PPB - 1));
			else if (r < 80)
				select_victim();
			else if (r < 95)
				free_block(($urandom_range(0, 9) < 7) ? hot[$urandom_range(0, 2)]
					: $urandom_range(0, NB - 1));
			else
				send_item(OP_RESERVED, ADDR_W'($urandom), BIDX_W'($urandom));
		end
	endtask

	// Invalidate every page of one block in a scrambled order, with repeats
	task automatic fill_block(input int blk);
		int stride, start;
		stride = 2 * $urandom_range(0, PPB / 2 - 1) + 1;
		start = $urandom_range(0, PPB - 1);
		for (int k = 0; k < PPB; k++) begin
			invalidate(blk, (start + k * stride) % PPB);
			if ($urandom_range(0, 9) == 0)
				invalidate(blk, (start + $urandom_range(0, k) * stride) % PPB);
			if ($urandom_range(0, 19) == 0)
				select_victim();
		end
		select_victim();
		if ($urandom_range(0, 1) == 0) begin
			free_block(blk);
			select_victim();
		end
	endtask

	task automatic run_directed();
		// empty tracker, reserved code with every field bit set
		select_victim();
		send_item(OP_RESERVED, '1, '1);
		// first and last page, repeat, tie broken by lowest index
		invalidate(0, 0);
		invalidate(0, 0);
		invalidate(NB - 1, PPB - 1);
		invalidate(9, 5);
		select_victim();
		free_block(0);
		select_victim();
		free_block(NB - 1);
		invalidate(NB - 1, PPB - 1);
		invalidate(NB - 1, PPB - 2);
		select_victim();
		free_block(9);
		free_block(200);
		// range running past the last block, empty range, one-block range
		drain();
		set_scan(9'd250, 9'd256);
		select_victim();
		drain();
		set_scan(9'd0, 9'd0);
		select_victim();
		drain();
		set_scan(9'h1FF, 9'd1);
		select_victim();
		drain();
		set_scan(9'd0, 9'd256);
	endtask

	// Result side: random stalls, calm stretches and one long hold-off on request
	initial begin : result_side
		int run_left;
		run_left = 0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				out_stall = 1'b1;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
				hold_off_req = 1'b0;
				out_stall = 1'b0;
				run_left = 0;
			end else if (calm) begin
				out_stall = 1'b0;
			end else if (run_left > 0) begin
				run_left--;
			end else begin
				out_stall = ($urandom_range(0, 3) == 0);
				run_left = out_stall ? pick_gap() : $urandom_range(0, 6);
			end
		end
	end

	// Check every result transfer
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			seen_result.victim_found = victim_found;
			seen_result.victim_block = victim_block;
			seen_result.victim_invalid_count = victim_invalid_count;
			seen_result.repeat_invalidate = repeat_invalidate;
			seen_result.block_all_invalid = block_all_invalid;
			board.compare_result(seen_result);
		end
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles, %0d results outstanding", cycles, board.pending());
		$display("end of test: mismatches");
		$finish;
	end

	initial begin : request_side
		int phase;
		phase = 0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		// registers are taken while the store clears
		set_scan(9'd0, 9'd256);
		run_directed();

		while (board.requests < ITEMS_TOTAL) begin
			// pause for a full drain and move the scan range
			if (phase % 3 == 0) begin
				drain();
				pick_setting(phase / 3);
			end
			calm = ($urandom_range(0, 4) == 0);
			// back-pressure: keep offering while the result side holds off
			if (phase == 2 || phase == 13) begin
				calm = 1'b1;
				hold_off_req = 1'b1;
			end
			choose_hot();
			if ($urandom_range(0, 2) == 0)
				fill_block(hot[0]);
			else
				mixed_burst($urandom_range(30, 70));
			phase++;
		end
		drain();
		calm = 1'b0;
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("covered %0d requests: %0d invalidates (%0d repeats), ", board.requests,
			board.n_inv, board.n_repeat, "%0d selections (%0d found), ", board.n_sel,
			board.n_found, "%0d frees, %0d reserved", board.n_free, board.n_other);
		$display("%0d results checked, %0d on fully invalid blocks, ", board.checked,
			board.n_full, "%0d scan settings, %0d mismatches", settings_used,
			board.errors);
		if (board.errors == 0 && board.pending() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
